FILE: sv/dpwm_pkg.sv
// Package for the dithered PWM compare generator.
// Holds widths, request codes, the dither pattern table and shared structs.
// No dependencies.
`default_nettype none

package dpwm_pkg;

   localparam int DITHER_SLOTS = 32;
   localparam int COL_W        = $clog2(DITHER_SLOTS);
   localparam int SLOT_W       = COL_W + 1;
   localparam int DUTY_W       = 16;
   localparam int PHASE_W      = COL_W;
   localparam int VALUE_W      = DUTY_W + PHASE_W;
   localparam int HALVES       = 2;
   localparam int HALF_AW      = 1;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   // One snapshot of a playback half.
   typedef struct packed {
      logic [DUTY_W-1:0]  duty;
      logic [PHASE_W-1:0] phase;
   } half_type;

   // Control carried by the stage between memory read and output register.
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } stage_type;

   // Row p, bit i: dither pattern bit for phase p in column i.
   localparam logic [DITHER_SLOTS-1:0] DITHER_ROWS [DITHER_SLOTS] = '{
      32'h00000000, 32'h80000000, 32'h80008000, 32'h80808000,
      32'h80808080, 32'h88808080, 32'h88808880, 32'h88888880,
      32'h88888888, 32'hA8888888, 32'hA888A888, 32'hAA88A888,
      32'hAA88AA88, 32'hAAA8AA88, 32'hAAA8AAA8, 32'hAAAAAAA8,
      32'hAAAAAAAA, 32'hEAAAAAAA, 32'hEAAAEAAA, 32'hFAAAEAAA,
      32'hFAAAFAAA, 32'hFEAAFAAA, 32'hFEAAFEAA, 32'hFFAAFEAA,
      32'hFFAAFFAA, 32'hFFEAFFAA, 32'hFFEAFFEA, 32'hFFFAFFEA,
      32'hFFFAFFFA, 32'hFFFEFFFA, 32'hFFFEFFFE, 32'hFFFFFFFE
   };

endpackage

`default_nettype wire

FILE: sv/dpwm_req_if.sv
// Request channel of the dithered PWM compare generator.
// Carries valid, ready and the load or tick item; uses dpwm_pkg widths.
`default_nettype none

interface dpwm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [dpwm_pkg::VALUE_W-1:0] pwm_value;

   modport source (output valid, output req_type, output pwm_value, input ready);
   modport sink   (input valid, input req_type, input pwm_value, output ready);
endinterface

`default_nettype wire

FILE: sv/dpwm_rsp_if.sv
// Result channel of the dithered PWM compare generator.
// Carries valid, ready, the compare value and its slot; uses dpwm_pkg widths.
`default_nettype none

interface dpwm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [dpwm_pkg::DUTY_W-1:0] compare_value;
   logic [dpwm_pkg::SLOT_W-1:0] slot_index;

   modport source (output valid, output compare_value, output slot_index, input ready);
   modport sink   (input valid, input compare_value, input slot_index, output ready);
endinterface

`default_nettype wire

FILE: sv/dpwm_half_mem.sv
// Snapshot memory for the two playback halves, with a registered read.
// Per-entry valid bits make unwritten entries read as zero; uses dpwm_pkg.
`default_nettype none

module dpwm_half_mem (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rd_en,
   input  wire logic [dpwm_pkg::HALF_AW-1:0] rd_addr,
   input  wire logic                         wr_en,
   input  wire logic [dpwm_pkg::HALF_AW-1:0] wr_addr,
   input  wire dpwm_pkg::half_type           wr_data,
   output dpwm_pkg::half_type                rd_data
);

   dpwm_pkg::half_type                  mem [dpwm_pkg::HALVES];
   logic [dpwm_pkg::HALVES-1:0]         entry_vld_ff;
   dpwm_pkg::half_type                  rd_data_ff;
   logic                                rd_vld_ff;

   // Read returns the old contents when the same entry is written.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_vld_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= entry_vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: sv/dpwm_out_stage.sv
// Compare computation and output register of the dithered PWM generator.
// Adds the dither bit to the duty with saturation; uses dpwm_pkg, dpwm_rsp_if.
`default_nettype none

module dpwm_out_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dpwm_pkg::stage_type s1,
   input  wire dpwm_pkg::half_type  half,
   output logic                     take,
   dpwm_rsp_if.source               rsp_ch
);

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [dpwm_pkg::DUTY_W-1:0] compare_ff;
   logic [dpwm_pkg::DUTY_W-1:0] compare_in;
   logic [dpwm_pkg::SLOT_W-1:0] slot_ff;
   logic                        dither_bit;
   logic [dpwm_pkg::DUTY_W:0]   sum;
   logic                        out_free;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign take     = s1.valid && out_free;

   always_comb begin
      dither_bit = dpwm_pkg::DITHER_ROWS[half.phase][s1.slot[dpwm_pkg::COL_W-1:0]];
      sum        = {1'b0, half.duty} + {{dpwm_pkg::DUTY_W{1'b0}}, dither_bit};
      compare_in = sum[dpwm_pkg::DUTY_W] ? '1 : sum[dpwm_pkg::DUTY_W-1:0];
      if (out_free) begin
         rsp_valid_in = s1.valid;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         compare_ff <= compare_in;
         slot_ff    <= s1.slot;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.compare_value = compare_ff;
   assign rsp_ch.slot_index    = slot_ff;

endmodule

`default_nettype wire

FILE: sv/dithered_pwm_compare_generator.sv
// Top level of the dithered PWM compare generator.
// Uses dpwm_pkg, dpwm_req_if, dpwm_rsp_if, dpwm_half_mem and dpwm_out_stage.
//
//   channel  | direction | handshake      | payload
//   ---------+-----------+----------------+-----------------------------------
//   req_ch   | in        | valid / ready  | req_type, pwm_value
//   rsp_ch   | out       | valid / ready  | compare_value, slot_index
//
// One item is accepted per cycle unless a stalled result side fills both stages.
// A tick item reads its half snapshot from the two-entry memory in the accept
// cycle; snapshot and slot are registered in the read stage, and the result
// moves on into the output register when that is free. A load item updates
// the staging registers in its accept cycle and gives no result. Reset
// clears the slot counter, the staging registers, the read stage, the output
// valid and the snapshot memory valid bits. A stalled result side holds the
// output register and read stage; req_ch.ready falls only when both are full.
`default_nettype none

module dithered_pwm_compare_generator (
   input  wire logic  clock,
   input  wire logic  reset,
   dpwm_req_if.sink   req_ch,
   dpwm_rsp_if.source rsp_ch
);

   logic [dpwm_pkg::SLOT_W-1:0] play_slot_ff;
   logic [dpwm_pkg::SLOT_W-1:0] play_slot_in;
   dpwm_pkg::half_type          staged_ff;
   dpwm_pkg::half_type          staged_in;
   dpwm_pkg::stage_type         s1_ff;
   dpwm_pkg::stage_type         s1_in;
   dpwm_pkg::half_type          half_rd;
   dpwm_pkg::req_kind_type      kind;
   logic                        accept;
   logic                        tick_acc;
   logic                        load_acc;
   logic                        s1_free;
   logic                        take;
   logic                        half_end;
   logic [dpwm_pkg::HALF_AW-1:0] half_sel;

   assign kind     = dpwm_pkg::req_kind_type'(req_ch.req_type);
   assign accept   = req_ch.valid && req_ch.ready;
   assign tick_acc = accept && (kind == dpwm_pkg::REQ_TICK);
   assign load_acc = accept && (kind == dpwm_pkg::REQ_LOAD);

   // The read stage frees up whenever its item moves into the output register.
   assign s1_free      = !s1_ff.valid || take;
   assign req_ch.ready = s1_free;

   // The upper slot bit picks the half; the last slot of a half refreshes
   // that same half from the staged value, after its own read.
   assign half_sel = play_slot_ff[dpwm_pkg::SLOT_W-1];
   assign half_end = &play_slot_ff[dpwm_pkg::COL_W-1:0];

   always_comb begin
      play_slot_in = play_slot_ff;
      staged_in    = staged_ff;
      s1_in        = s1_ff;
      if (tick_acc) begin
         play_slot_in = play_slot_ff + 1'b1;
      end
      if (load_acc) begin
         staged_in.duty  = req_ch.pwm_value[dpwm_pkg::VALUE_W-1:dpwm_pkg::PHASE_W];
         staged_in.phase = req_ch.pwm_value[dpwm_pkg::PHASE_W-1:0];
      end
      if (s1_free) begin
         s1_in.valid = tick_acc;
         s1_in.slot  = play_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_slot_ff <= '0;
         staged_ff    <= '0;
         s1_ff        <= '0;
      end else begin
         play_slot_ff <= play_slot_in;
         staged_ff    <= staged_in;
         s1_ff        <= s1_in;
      end
   end

   dpwm_half_mem u_half_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (tick_acc),
      .rd_addr (half_sel),
      .wr_en   (tick_acc && half_end),
      .wr_addr (half_sel),
      .wr_data (staged_ff),
      .rd_data (half_rd)
   );

   dpwm_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .s1     (s1_ff),
      .half   (half_rd),
      .take   (take),
      .rsp_ch (rsp_ch)
   );

`ifndef SYNTHESIS
   // Every accepted tick moves playback on by exactly one slot.
   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      tick_acc |=> play_slot_ff == $past(play_slot_ff) + 1'b1)
      else $error("play slot did not advance by one on a tick");

   // A read-stage item that cannot move on keeps its slot.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_ff.valid && !take |=> s1_ff.valid && s1_ff.slot == $past(s1_ff.slot))
      else $error("read stage lost its item while stalled");

   // A tick entering the read stage carries the slot that was current.
   a_s1_slot: assert property (@(posedge clock) disable iff (reset)
      tick_acc |=> s1_ff.valid && s1_ff.slot == $past(play_slot_ff))
      else $error("read stage slot does not match the accepted tick");
`endif

endmodule

`default_nettype wire

FILE: test/dpwm_compare_checker.sv
// Checker for the dithered PWM compare generator: tracks the staging registers,
// the two playback halves and the slot counter, and compares each compare item.
// Depends on dpwm_pkg, dpwm_req_if and dpwm_rsp_if.
`default_nettype none

module dpwm_compare_checker (
   input  wire logic clock,
   input  wire logic reset,
   dpwm_req_if       req_ch,
   dpwm_rsp_if       rsp_ch,
   output int        mismatch_count,
   output int        pending_count
);

   localparam int REPORT_LIMIT = 10;

   // Dither pattern: row p, bit i is the extra count for phase p in column i.
   localparam logic [dpwm_pkg::DITHER_SLOTS-1:0] PATTERN_ROWS [dpwm_pkg::DITHER_SLOTS] = '{
      32'h00000000, 32'h80000000, 32'h80008000, 32'h80808000,
      32'h80808080, 32'h88808080, 32'h88808880, 32'h88888880,
      32'h88888888, 32'hA8888888, 32'hA888A888, 32'hAA88A888,
      32'hAA88AA88, 32'hAAA8AA88, 32'hAAA8AAA8, 32'hAAAAAAA8,
      32'hAAAAAAAA, 32'hEAAAAAAA, 32'hEAAAEAAA, 32'hFAAAEAAA,
      32'hFAAAFAAA, 32'hFEAAFAAA, 32'hFEAAFEAA, 32'hFFAAFEAA,
      32'hFFAAFFAA, 32'hFFEAFFAA, 32'hFFEAFFEA, 32'hFFFAFFEA,
      32'hFFFAFFFA, 32'hFFFEFFFA, 32'hFFFEFFFE, 32'hFFFFFFFE
   };

   typedef struct packed {
      logic [dpwm_pkg::DUTY_W-1:0] compare_value;
      logic [dpwm_pkg::SLOT_W-1:0] slot_index;
   } compare_item_type;

   logic [dpwm_pkg::DUTY_W-1:0]  staged_duty;
   logic [dpwm_pkg::PHASE_W-1:0] staged_phase;
   logic [dpwm_pkg::DUTY_W-1:0]  snap_duty  [dpwm_pkg::HALVES];
   logic [dpwm_pkg::PHASE_W-1:0] snap_phase [dpwm_pkg::HALVES];
   logic [dpwm_pkg::SLOT_W-1:0]  next_slot;
   compare_item_type             pending_compares [$];

   // Compare value of one slot from its half's snapshot, saturated at full scale.
   function automatic compare_item_type compare_for_slot(
      input logic [dpwm_pkg::SLOT_W-1:0] slot);
      logic                         half;
      logic [dpwm_pkg::COL_W-1:0]   col;
      logic [dpwm_pkg::DUTY_W:0]    sum;
      compare_item_type             item;
      half = slot[dpwm_pkg::SLOT_W-1];
      col  = slot[dpwm_pkg::COL_W-1:0];
      sum  = {1'b0, snap_duty[half]} + PATTERN_ROWS[snap_phase[half]][col];
      item.compare_value = sum[dpwm_pkg::DUTY_W] ? {dpwm_pkg::DUTY_W{1'b1}}
                                                 : sum[dpwm_pkg::DUTY_W-1:0];
      item.slot_index    = slot;
      return item;
   endfunction

   always @(posedge clock) begin : track
      compare_item_type got;
      compare_item_type want;
      if (reset) begin
         staged_duty  = '0;
         staged_phase = '0;
         for (int h = 0; h < dpwm_pkg::HALVES; h++) begin
            snap_duty[h]  = '0;
            snap_phase[h] = '0;
         end
         next_slot = '0;
         pending_compares.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.req_type == dpwm_pkg::REQ_LOAD) begin
               staged_duty  = req_ch.pwm_value[dpwm_pkg::VALUE_W-1:dpwm_pkg::PHASE_W];
               staged_phase = req_ch.pwm_value[dpwm_pkg::PHASE_W-1:0];
            end else begin
               pending_compares.push_back(compare_for_slot(next_slot));
               // The last slot of a half reloads that half from the staging registers.
               if (next_slot[dpwm_pkg::COL_W-1:0] == {dpwm_pkg::COL_W{1'b1}}) begin
                  snap_duty[next_slot[dpwm_pkg::SLOT_W-1]]  = staged_duty;
                  snap_phase[next_slot[dpwm_pkg::SLOT_W-1]] = staged_phase;
               end
               next_slot = next_slot + 1'b1;
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.compare_value = rsp_ch.compare_value;
            got.slot_index    = rsp_ch.slot_index;
            if (pending_compares.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("unexpected compare item: compare_value %0d slot_index %0d",
                           got.compare_value, got.slot_index);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = pending_compares.pop_front();
               if (got.compare_value !== want.compare_value ||
                   got.slot_index !== want.slot_index) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display({"compare item mismatch: compare_value expected %0d got %0d, ",
                               "slot_index expected %0d got %0d"},
                              want.compare_value, got.compare_value,
                              want.slot_index, got.slot_index);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
      end
      pending_count = pending_compares.size();
   end

endmodule

`default_nettype wire

FILE: test/dithered_pwm_compare_generator_test.sv
// Top of the dithered PWM compare generator test: clock, reset, stimulus,
// result-side stalls, watchdog and verdict.
// Depends on dpwm_pkg, both channel interfaces, the block and dpwm_compare_checker.
`default_nettype none

module dithered_pwm_compare_generator_test;

   localparam int RANDOM_ITEMS   = 1530;
   // Longest quiet stretch in a correct run is the longest sender gap on top of
   // the longest result stall; the limits leave a wide margin over that.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_LIMIT    = 2000;
   // The block registers a tick result in the read stage, then in the output register.
   localparam int SETTLE_CYCLES  = 10;
   localparam logic [dpwm_pkg::VALUE_W-1:0] VALUE_MAX = {dpwm_pkg::VALUE_W{1'b1}};

   // Ways the result side holds off ready; each lasts for a random stretch.
   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_RUNS
   } stall_mode_type;

   logic           clock;
   logic           reset;
   int             mismatch_count;
   int             pending_count;
   int             burst_left;
   stall_mode_type stall_mode;
   int             stall_mode_left;
   int             stall_run_left;
   int             stall_phase;

   dpwm_req_if req_ch ();
   dpwm_rsp_if rsp_ch ();

   dithered_pwm_compare_generator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // The checker watches both channels, predicts every compare item and counts
   // failures; this module only makes stimulus and decides the verdict.
   dpwm_compare_checker compare_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Send one item. The sender works in bursts; when a burst runs out it may
   // drop valid for a random gap before the next burst starts. Valid is only
   // lowered when a gap is actually taken, so back-to-back items keep it high.
   task automatic send_item(input dpwm_pkg::req_kind_type kind,
                            input logic [dpwm_pkg::VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // Now and then a long burst gives a stretch with no idling at all.
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left = burst_left - 1;
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= kind;
      req_ch.pwm_value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Load values lean toward full scale so that saturation and the top phase
   // are reached often; the rest covers every bit of the field.
   function automatic logic [dpwm_pkg::VALUE_W-1:0] pick_load_value();
      logic [dpwm_pkg::PHASE_W-1:0] phase;
      logic [dpwm_pkg::VALUE_W-1:0] value;
      phase = dpwm_pkg::PHASE_W'($urandom_range(0, dpwm_pkg::DITHER_SLOTS - 1));
      value = dpwm_pkg::VALUE_W'($urandom_range(0, (1 << dpwm_pkg::VALUE_W) - 1));
      case ($urandom_range(0, 9))
         0, 1:    return VALUE_MAX;
         2:       return '0;
         3, 4:    return {{dpwm_pkg::DUTY_W{1'b1}}, phase};
         5:       return {{dpwm_pkg::DUTY_W{1'b0}}, phase};
         default: return value;
      endcase
   endfunction

   // Result-side stalls. Each mode runs for a random number of cycles, so the
   // stalls land on every phase of the playback and of the output pipeline.
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      = stall_mode_type'($urandom_range(0, 3));
         stall_mode_left = $urandom_range(20, 300);
      end else begin
         stall_mode_left = stall_mode_left - 1;
      end
      stall_phase = (stall_phase + 1) % 5;
      case (stall_mode)
         STALL_NONE: begin
            rsp_ch.ready <= 1'b1;
         end
         STALL_RANDOM: begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
         STALL_PERIODIC: begin
            rsp_ch.ready <= (stall_phase < 2);
         end
         default: begin
            // Long holds of random length with ready high in between.
            if (stall_run_left > 0) begin
               stall_run_left = stall_run_left - 1;
               rsp_ch.ready <= 1'b0;
            end else begin
               rsp_ch.ready <= 1'b1;
               if ($urandom_range(0, 7) == 0)
                  stall_run_left = $urandom_range(5, 40);
            end
         end
      endcase
   end

   // The watchdog ends the run when nothing has been accepted on either
   // channel for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
      end
      $display("dithered_pwm_compare_generator test failed");
      $finish;
   end

   initial begin : stimulus
      int                           drain_cycles;
      logic [dpwm_pkg::VALUE_W-1:0] noise;

      // Every input of the block is known from time zero.
      req_ch.valid     = 1'b0;
      req_ch.req_type  = dpwm_pkg::REQ_LOAD;
      req_ch.pwm_value = '0;
      rsp_ch.ready     = 1'b0;
      reset            = 1'b1;
      burst_left       = 0;
      stall_mode       = STALL_NONE;
      stall_mode_left  = 0;
      stall_run_left   = 0;
      stall_phase      = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Ticks before any load must play zero from the first half.
      send_item(dpwm_pkg::REQ_TICK, '0);
      send_item(dpwm_pkg::REQ_TICK, VALUE_MAX);
      send_item(dpwm_pkg::REQ_TICK, '0);
      // Extremes of the load field: full scale with the top phase, then zero.
      send_item(dpwm_pkg::REQ_LOAD, VALUE_MAX);
      send_item(dpwm_pkg::REQ_TICK, VALUE_MAX);
      send_item(dpwm_pkg::REQ_LOAD, '0);
      // Loads while playing only touch the staging registers.
      send_item(dpwm_pkg::REQ_LOAD, dpwm_pkg::VALUE_W'(32));
      send_item(dpwm_pkg::REQ_LOAD, dpwm_pkg::VALUE_W'(31));
      send_item(dpwm_pkg::REQ_TICK, '0);
      send_item(dpwm_pkg::REQ_LOAD,
                {{dpwm_pkg::DUTY_W{1'b1}}, {dpwm_pkg::PHASE_W{1'b0}}});
      send_item(dpwm_pkg::REQ_LOAD, dpwm_pkg::VALUE_W'(1));
      send_item(dpwm_pkg::REQ_LOAD, dpwm_pkg::VALUE_W'(16));
      send_item(dpwm_pkg::REQ_TICK, '0);
      send_item(dpwm_pkg::REQ_LOAD, {1'b1, {(dpwm_pkg::VALUE_W-1){1'b0}}});
      send_item(dpwm_pkg::REQ_LOAD, {{dpwm_pkg::DUTY_W{1'b1}}, 5'd1});
      send_item(dpwm_pkg::REQ_TICK, '0);
      // Full scale again so the first refreshes pick up a saturating value.
      send_item(dpwm_pkg::REQ_LOAD, VALUE_MAX);
      send_item(dpwm_pkg::REQ_TICK, '0);
      send_item(dpwm_pkg::REQ_TICK, VALUE_MAX);

      // Random part: mostly ticks, which walk the playback through slot wraps
      // and half refreshes, with loads scattered in between. Ticks carry random
      // values too, which the block must ignore.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            send_item(dpwm_pkg::REQ_LOAD, pick_load_value());
         end else begin
            noise = dpwm_pkg::VALUE_W'($urandom_range(0, (1 << dpwm_pkg::VALUE_W) - 1));
            send_item(dpwm_pkg::REQ_TICK, noise);
         end
      end
      req_ch.valid <= 1'b0;

      // Let the outstanding compare items drain, then give the pipeline time
      // to show any stray result.
      drain_cycles = 0;
      while (pending_count != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles = drain_cycles + 1;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (drain_cycles < DRAIN_LIMIT && mismatch_count == 0 && pending_count == 0)
         $display("dithered_pwm_compare_generator test passed");
      else
         $display("dithered_pwm_compare_generator test failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
sv/dpwm_pkg.sv
sv/dpwm_req_if.sv
sv/dpwm_rsp_if.sv
sv/dpwm_half_mem.sv
sv/dpwm_out_stage.sv
sv/dithered_pwm_compare_generator.sv
test/dpwm_compare_checker.sv
test/dithered_pwm_compare_generator_test.sv
